// ===== rtl/voxel_sample_decode_scale_macros.svh =====
// assertion macros shared by the voxel decode rtl
// no dependencies
`ifndef VOXEL_SAMPLE_DECODE_SCALE_MACROS_SVH
`define VOXEL_SAMPLE_DECODE_SCALE_MACROS_SVH

`define VSD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define VSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/vsd_pkg.sv =====
// types, codes and float helpers for the voxel decode block
// no dependencies
`timescale 1ns / 1ps
package vsd_pkg;
   localparam logic [15:0] TYPE_U8  = 16'd2;
   localparam logic [15:0] TYPE_S16 = 16'd4;
   localparam logic [15:0] TYPE_S32 = 16'd8;
   localparam logic [15:0] TYPE_F32 = 16'd16;
   localparam logic [1:0] CSR_TYPE  = 2'd0;
   localparam logic [1:0] CSR_BIG   = 2'd1;
   localparam logic [1:0] CSR_SLOPE = 2'd2;
   localparam logic [1:0] CSR_INTER = 2'd3;
   localparam logic [31:0] CANON_QNAN = 32'h7FC0_0000;
   localparam int QDEPTH = 2;

   typedef struct packed {
      logic [31:0] value;
      logic        bad;
   } item_type;

   typedef struct packed {
      logic        ovalid;
      logic [31:0] value;
      logic        bad;
   } stage_type;

   // count leading zeros of a 32 bit word
   function automatic logic [5:0] clz32(input logic [31:0] x);
      logic [5:0] n;
      logic       found;
      n = 6'd32;
      found = 1'b0;
      for (int i = 31; i >= 0; i--) begin
         if (!found && x[i]) begin
            n = 6'(31 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // round a normalized 64 bit significand (msb at 63) to binary32
   // exp is the biased exponent of bit 63, may be <=0 for subnormals
   function automatic logic [31:0] pack_round(input logic sgn, input logic signed [11:0] exp,
                                              input logic [63:0] sig);
      logic [63:0] s;
      logic        sticky;
      logic [24:0] m;
      logic        g, r;
      logic signed [11:0] e;
      logic [6:0] sh;
      s = sig;
      e = exp;
      sticky = 1'b0;
      if (e < 12'sd1) begin
         sh = (e < -12'sd62) ? 7'd64 : 7'(12'sd1 - e);
         for (int i = 0; i < 64; i++)
            if (i < sh && s[i]) sticky = 1'b1;
         s = (sh >= 7'd64) ? 64'd0 : (s >> sh);
         e = 12'sd0;
      end
      m = {1'b0, s[63:40]};
      g = s[39];
      r = sticky | (|s[38:0]);
      if (g && (r || m[0])) m = m + 25'd1;
      if (e == 12'sd0) begin
         if (m[23]) e = 12'sd1;
      end else if (m[24]) begin
         m = m >> 1;
         e = e + 12'sd1;
      end
      if (e >= 12'sd255) return {sgn, 8'hFF, 23'd0};
      return {sgn, e[7:0], m[22:0]};
   endfunction
endpackage

// ===== rtl/vsd_front.sv =====
// front: byte order, type decode and conversion to binary32
// depends on vsd_pkg
`timescale 1ns / 1ps
module vsd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [31:0]       raw,
   input  logic [15:0]       stype,
   input  logic              big,
   output logic              out_valid,
   input  logic              out_ready,
   output vsd_pkg::item_type out_item
);
   import vsd_pkg::*;

   item_type   q_ff [QDEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   item_type   conv;
   logic [31:0] sw, mag, fv, nsig;
   logic [15:0] h;
   logic        neg;
   logic [5:0]  lz;
   logic [63:0] norm;
   logic        push, pop;

   always_comb begin
      sw = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
      h = big ? {raw[7:0], raw[15:8]} : raw[15:0];
      nsig = big ? sw : raw;
      conv.bad = 1'b0;
      conv.value = 32'd0;
      neg = 1'b0;
      mag = 32'd0;
      fv = 32'd0;
      case (stype)
         TYPE_U8: mag = {24'd0, raw[7:0]};
         TYPE_S16: begin
            neg = h[15];
            mag = neg ? 32'(-{{16{h[15]}}, h}) : {16'd0, h};
         end
         TYPE_S32: begin
            neg = nsig[31];
            mag = neg ? (~nsig + 32'd1) : nsig;
         end
         TYPE_F32: fv = big ? sw : raw;
         default: conv.bad = 1'b1;
      endcase
      lz = clz32(mag);
      norm = {mag << lz[4:0], 32'd0};
      if (conv.bad) conv.value = 32'd0;
      else if (stype == TYPE_F32) conv.value = fv;
      else if (mag == 32'd0) conv.value = 32'd0;
      else conv.value = pack_round(neg, 12'sd158 - 12'(lz), norm);
   end

   assign in_ready = cnt_ff != 2'(QDEPTH);
   assign push = in_valid && in_ready;
   assign out_valid = cnt_ff != 2'd0;
   assign pop = out_valid && out_ready;
   assign out_item = q_ff[rp_ff];
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
      end
      if (push) q_ff[wp_ff] <= conv;
   end

   `include "voxel_sample_decode_scale_macros.svh"
   `VSD_ASSERT_IMPL(a_cnt_max, clock, reset, 1'b1, cnt_ff <= 2'(QDEPTH))
   `VSD_ASSERT_NEXT(a_cnt_up, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 2'd1)
   `VSD_ASSERT_NEXT(a_cnt_dn, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - 2'd1)
endmodule

// ===== rtl/vsd_back.sv =====
// back: multiply by slope, add intercept (a zero slope passes the value through), nan canonicalization
// depends on vsd_pkg
`timescale 1ns / 1ps
module vsd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  vsd_pkg::item_type in_item,
   input  logic [31:0]       slope,
   input  logic [31:0]       inter,
   output logic              out_valid,
   input  logic              out_ready,
   output vsd_pkg::item_type out_item
);
   import vsd_pkg::*;

   // stage 1: product, stage 2: product select, stage 3: sum and output
   stage_type s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   logic [31:0] p_ff, p_in;
   logic        en1, en2, en3;
   logic        sz;

   function automatic logic isnan(input logic [31:0] f);
      return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
   endfunction

   function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
      logic sgn;
      logic [23:0] ma, mb;
      logic signed [11:0] ea, eb, e;
      logic [47:0] pr;
      logic [5:0] lz;
      logic [63:0] n;
      sgn = a[31] ^ b[31];
      if (isnan(a) || isnan(b)) return CANON_QNAN;
      if (a[30:23] == 8'hFF) return (b[30:0] == 31'd0) ? CANON_QNAN : {sgn, 8'hFF, 23'd0};
      if (b[30:23] == 8'hFF) return (a[30:0] == 31'd0) ? CANON_QNAN : {sgn, 8'hFF, 23'd0};
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      ea = (a[30:23] == 8'd0) ? 12'sd1 : 12'(a[30:23]);
      eb = (b[30:23] == 8'd0) ? 12'sd1 : 12'(b[30:23]);
      pr = ma * mb;
      lz = clz32(pr[47:16]);
      if (lz == 6'd32) lz = 6'd32 + clz32({pr[15:0], 16'hFFFF});
      n = {pr, 16'd0} << lz;
      e = ea + eb - 12'sd126 - 12'(lz);
      return pack_round(sgn, e, n);
   endfunction

   function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
      logic [23:0] ma, mb;
      logic [8:0] ea, eb, d;
      logic [63:0] xa, xb, xs, big_m, sml;
      logic sa, sb, sgn, st;
      logic [5:0] lz;
      logic [63:0] n;
      if (isnan(a) || isnan(b)) return CANON_QNAN;
      if (a[30:23] == 8'hFF && b[30:23] == 8'hFF)
         return (a[31] != b[31]) ? CANON_QNAN : a;
      if (a[30:23] == 8'hFF) return a;
      if (b[30:23] == 8'hFF) return b;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
      if (a[30:0] == 31'd0) return b;
      if (b[30:0] == 31'd0) return a;
      ma = {a[30:23] != 8'd0, a[22:0]};
      mb = {b[30:23] != 8'd0, b[22:0]};
      ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
      eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
      sa = a[31];
      sb = b[31];
      if ({ea, ma} < {eb, mb}) begin
         {ea, eb} = {eb, ea};
         {ma, mb} = {mb, ma};
         {sa, sb} = {sb, sa};
      end
      d = ea - eb;
      big_m = {2'b0, ma, 38'd0};
      xb = {2'b0, mb, 38'd0};
      st = 1'b0;
      if (d > 9'd40) begin
         sml = 64'd1;
      end else begin
         sml = xb >> d;
         for (int i = 0; i < 41; i++) if (i < d && xb[i]) st = 1'b1;
         sml[0] = sml[0] | st;
      end
      xa = big_m;
      xs = (sa == sb) ? xa + sml : xa - sml;
      if (xs == 64'd0) return 32'd0;
      sgn = sa;
      lz = clz32(xs[63:32]);
      if (lz == 6'd32) lz = 6'd32 + clz32(xs[31:0]);
      n = xs << lz;
      return pack_round(sgn, 12'(ea) + 12'sd2 - 12'(lz), n);
   endfunction

   assign sz = slope[30:0] == 31'd0;
   assign en3 = !s3_ff.ovalid || out_ready;
   assign en2 = !s2_ff.ovalid || en3;
   assign en1 = !s1_ff.ovalid || en2;
   assign in_ready = en1;

   always_comb begin
      s1_in = '{ovalid: in_valid, value: in_item.value, bad: in_item.bad};
      p_in = fmul(in_item.value, slope);
      s2_in = s1_ff;
      if (!s1_ff.bad && !sz) s2_in.value = p_ff;
      s3_in = s2_ff;
      if (!s2_ff.bad) begin
         if (!sz) s3_in.value = fadd(s2_ff.value, inter);
         else if (isnan(s2_ff.value)) s3_in.value = CANON_QNAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.ovalid <= 1'b0;
         s2_ff.ovalid <= 1'b0;
         s3_ff.ovalid <= 1'b0;
      end else begin
         if (en1) s1_ff.ovalid <= s1_in.ovalid;
         if (en2) s2_ff.ovalid <= s2_in.ovalid;
         if (en3) s3_ff.ovalid <= s3_in.ovalid;
      end
      if (en1) begin
         s1_ff.value <= s1_in.value;
         s1_ff.bad <= s1_in.bad;
         p_ff <= p_in;
      end
      if (en2) begin
         s2_ff.value <= s2_in.value;
         s2_ff.bad <= s2_in.bad;
      end
      if (en3) begin
         s3_ff.value <= s3_in.value;
         s3_ff.bad <= s3_in.bad;
      end
   end

   assign out_valid = s3_ff.ovalid;
   assign out_item = '{value: s3_ff.value, bad: s3_ff.bad};

   `include "voxel_sample_decode_scale_macros.svh"
   `VSD_ASSERT_NEXT(a_hold, clock, reset, out_valid && !out_ready, out_valid && $stable(s3_ff.value))
   `VSD_ASSERT_IMPL(a_bad_zero, clock, reset, out_valid && s3_ff.bad, s3_ff.value == 32'd0)
   `VSD_ASSERT_IMPL(a_nan, clock, reset, out_valid && isnan(s3_ff.value), s3_ff.value == CANON_QNAN)
endmodule

// ===== rtl/voxel_sample_decode_scale.sv =====
// top level of the voxel sample decoder with linear scaling
// depends on vsd_pkg, vsd_front, vsd_back
`timescale 1ns / 1ps
// usage:
// req_ channel carries one raw voxel word per beat, first stored byte in
// bits 7:0. csr_ port writes sample type (0), byte order (1), slope (2) and
// intercept (3); write only while no word is in flight.
// rsp_ channel returns one word per input: binary32 value and, in tuser,
// the unsupported type flag (value is zero then).
// the front decodes and converts combinationally into a two entry queue; the
// back multiplies by the slope, adds the intercept (a zero slope passes the
// value through) and registers the result in three stages. throughput is
// one word per cycle while rsp_tready stays high, set by the back pipeline.
// reset clears the queue and pipeline and loads type uint8, little endian,
// zero slope and intercept. when the receiver holds rsp_tready low the
// pipeline holds, the queue fills and req_tready drops; nothing is lost.
module voxel_sample_decode_scale (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // raw_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // scaled_value
   output logic        rsp_tuser,   // unsupported_type
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import vsd_pkg::*;

   logic [15:0] type_ff;
   logic        big_ff;
   logic [31:0] slope_ff, inter_ff;
   logic        mid_valid, mid_ready;
   item_type    mid_item, out_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff <= TYPE_U8;
         big_ff <= 1'b0;
         slope_ff <= 32'd0;
         inter_ff <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TYPE:  type_ff <= csr_wdata[15:0];
            CSR_BIG:   big_ff <= csr_wdata[0];
            CSR_SLOPE: slope_ff <= csr_wdata;
            CSR_INTER: inter_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   vsd_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .raw(req_tdata),
      .stype(type_ff), .big(big_ff),
      .out_valid(mid_valid), .out_ready(mid_ready), .out_item(mid_item)
   );

   vsd_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(mid_valid), .in_ready(mid_ready), .in_item(mid_item),
      .slope(slope_ff), .inter(inter_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_item(out_item)
   );

   assign rsp_tdata = out_item.value;
   assign rsp_tuser = out_item.bad;
endmodule

// ===== bench/tb_voxel_sample_decode_scale.sv =====
// self-checking bench for voxel_sample_decode_scale: voxel words are streamed
// in, checked against a binary32 decode-and-scale predictor; depends on vsd_pkg
`timescale 1ns / 1ps
module tb_voxel_sample_decode_scale;
   import vsd_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam real TWO_M149 = 2.0 ** (-149);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_TYPE;
   logic [31:0] csr_wdata = '0;

   typedef struct packed {
      logic [31:0] value;
      logic        bad;
   } voxel_out_type;

   logic [15:0] cfg_type = TYPE_U8;
   logic        cfg_big = 1'b0;
   logic [31:0] cfg_slope = '0;
   logic [31:0] cfg_inter = '0;

   logic [31:0]   pending_words[$];
   voxel_out_type expected_voxels[$];
   int          errors = 0;
   int          cycles = 0;
   int          gap_left = 0;
   int          burst_left = 1;
   int          hold_cnt = 0;
   int          stall_mode = 0;
   bit          want_hold = 1'b0;
   bit          hold_taken = 1'b0;

   voxel_sample_decode_scale uut (.*);

   always #4 clock = ~clock;

   function automatic real f32_to_real(input logic [31:0] f);
      real r;
      if (f[30:23] == 8'hFF) return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'd0});
      if (f[30:23] == 8'h00) begin
         r = real'(f[22:0]) * TWO_M149;
         return f[31] ? -r : r;
      end
      return $bitstoreal({f[31], 11'(f[30:23] + 11'd896), f[22:0], 29'd0});
   endfunction

   // round a double to binary32, nearest even, subnormals kept
   function automatic logic [31:0] real_to_f32(input real r);
      logic [63:0] d, sig, q, rem, half;
      logic        s;
      int          fe, sh;
      d = $realtobits(r);
      s = d[63];
      if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CANON_QNAN : {s, 8'hFF, 23'd0};
      if (d[62:52] == 11'h000) return {s, 31'd0};
      fe = int'(d[62:52]) - 1023 + 127;
      if (fe >= 255) return {s, 8'hFF, 23'd0};
      sig = {11'd0, 1'b1, d[51:0]};
      sh = (fe >= 1) ? 29 : 30 - fe;
      if (sh > 60) sh = 60;
      q = sig >> sh;
      rem = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      if (fe < 1) return {s, q[30:0]};
      if (q[24]) begin
         q = q >> 1;
         fe++;
      end
      if (fe >= 255) return {s, 8'hFF, 23'd0};
      return {s, 8'(fe), q[22:0]};
   endfunction

   function automatic voxel_out_type decode_scale(input logic [31:0] w);
      voxel_out_type o;
      logic [15:0] h;
      logic [31:0] u, v;
      real         p;
      o.bad = 1'b0;
      u = cfg_big ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
      h = cfg_big ? {w[7:0], w[15:8]} : w[15:0];
      case (cfg_type)
         TYPE_U8:  v = real_to_f32(real'(w[7:0]));
         TYPE_S16: v = real_to_f32(real'($signed(h)));
         TYPE_S32: v = real_to_f32(real'($signed(u)));
         TYPE_F32: v = real_to_f32(f32_to_real(u));
         default: begin
            o.value = '0;
            o.bad = 1'b1;
            return o;
         end
      endcase
      if (cfg_slope[30:0] == 31'd0) begin
         o.value = v;
      end else begin
         p = f32_to_real(v) * f32_to_real(cfg_slope);
         o.value = real_to_f32(f32_to_real(real_to_f32(p)) + f32_to_real(cfg_inter));
      end
      return o;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_voxels.push_back(decode_scale(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_tdata <= pending_words.pop_front();
               req_tvalid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      voxel_out_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_voxels.size() == 0) begin
               report("unexpected word", rsp_tdata, 32'd0);
            end else begin
               want = expected_voxels.pop_front();
               if (rsp_tdata !== want.value) report("scaled_value", rsp_tdata, want.value);
               if (rsp_tuser !== want.bad) report("unsupported_type", 32'(rsp_tuser),
                                                  32'(want.bad));
            end
         end
         if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
         if (want_hold && !hold_taken) begin
            hold_taken = 1'b1;
            hold_cnt = 200;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 9) > 2);
               2: rsp_tready <= cycles[0];
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_TYPE:  cfg_type = data[15:0];
         CSR_BIG:   cfg_big = data[0];
         CSR_SLOPE: cfg_slope = data;
         default:   cfg_inter = data;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_mode(input logic [15:0] t, input logic b, input logic [31:0] sl,
                           input logic [31:0] ic);
      write_reg(CSR_TYPE, {16'd0, t});
      write_reg(CSR_BIG, {31'd0, b});
      write_reg(CSR_SLOPE, sl);
      write_reg(CSR_INTER, ic);
   endtask

   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (pending_words.size() != 0 || req_tvalid || expected_voxels.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_float();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return {1'($urandom()), 8'($urandom_range(0, 2)), 23'($urandom())};
         2: return {1'($urandom()), 8'($urandom_range(250, 255)), 23'($urandom())};
         3: return {1'($urandom()), 31'd0};
         default: return {1'($urandom()), 8'($urandom_range(110, 145)), 23'($urandom())};
      endcase
   endfunction

   function automatic logic [15:0] rand_type();
      case ($urandom_range(0, 8))
         0: return TYPE_U8;
         1, 2: return TYPE_S16;
         3, 4: return TYPE_S32;
         5, 6, 7: return TYPE_F32;
         default: return 16'($urandom());
      endcase
   endfunction

   initial begin
      logic [31:0] specials[$];
      specials = '{32'h0000_0000, 32'h0000_00FF, 32'hFFFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h0000_8000, 32'h0000_0080, 32'h7F80_0000,
                   32'h7FC0_0001, 32'hFF80_0000, 32'h0000_0001, 32'h0100_0001};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, then each type with a few extremes
      foreach (specials[i]) pending_words.push_back(specials[i]);
      drain();
      set_mode(TYPE_S16, 1'b1, 32'h3FC0_0000, 32'hC000_0000);
      pending_words.push_back(32'h0000_0080);
      pending_words.push_back(32'h0000_FF7F);
      drain();
      set_mode(TYPE_S32, 1'b0, 32'h8000_0000, 32'h3F80_0000);
      pending_words.push_back(32'h7FFF_FFFF);
      pending_words.push_back(32'h8000_0001);
      drain();
      set_mode(TYPE_F32, 1'b1, 32'h0080_0000, 32'h0000_0000);
      pending_words.push_back(32'h0000_C03F);
      pending_words.push_back(32'h0100_8000);
      drain();
      set_mode(TYPE_F32, 1'b0, 32'h7F7F_FFFF, 32'hFF80_0000);
      pending_words.push_back(32'h4000_0000);
      pending_words.push_back(32'h0000_0000);
      drain();
      set_mode(16'h8000, 1'b0, 32'h3F80_0000, 32'h0000_0000);
      pending_words.push_back(32'h1234_5678);
      drain();
      set_mode(16'h7FFF, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
      pending_words.push_back(32'hFFFF_FFFF);
      drain();

      // random settings and words
      for (int ph = 0; ph < 10; ph++) begin
         set_mode(rand_type(), 1'($urandom()),
                  ($urandom_range(0, 4) == 0) ? {1'($urandom()), 31'd0} : rand_float(),
                  ($urandom_range(0, 3) == 0) ? 32'd0 : rand_float());
         if (ph == 4) want_hold = 1'b1;
         for (int i = 0; i < 50; i++)
            pending_words.push_back((cfg_type == TYPE_F32) ? rand_float() : $urandom());
         drain();
      end

      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
